/* hw/rtl/apc_pkg.sv */
// apc_pkg: shared types and constants of the animation phase controller
// no dependencies; imported by every module of the block
`default_nettype none
package apc_pkg;

  localparam int PHASE_W = 24;
  localparam int WEIGHT_W = 25;
  localparam int MODE_W = 3;
  localparam int DIVD_W = 50;
  localparam int DIVS_W = 25;

  localparam logic [24:0] ONE_Q24 = 25'd16777216;
  localparam logic [23:0] NEAR_ONE = 24'd16777199;
  localparam logic [47:0] DELTA_MAX = 48'hFFFF_FFFF_FFFF;

  // mode codes
  localparam logic [2:0] MODE_IDLE = 3'd0;
  localparam logic [2:0] MODE_ONCE = 3'd1;
  localparam logic [2:0] MODE_LOOP = 3'd2;
  localparam logic [2:0] MODE_SUB = 3'd3;
  localparam logic [2:0] MODE_STOPPED = 3'd4;

  // register indexes
  localparam logic [2:0] REG_PLAY_DUR = 3'd0;
  localparam logic [2:0] REG_BLEND_DUR = 3'd1;
  localparam logic [2:0] REG_RANGE_START = 3'd2;
  localparam logic [2:0] REG_RANGE_END = 3'd3;
  localparam logic [2:0] REG_PLAY_FWD = 3'd4;
  localparam logic [2:0] REG_SMOOTH = 3'd5;
  localparam logic [2:0] REG_START_PHASE = 3'd6;
  localparam logic [2:0] REG_USE_DEFAULT = 3'd7;

  // divider operand select
  typedef enum logic [1:0] {
    DSEL_BLEND,
    DSEL_PLAY,
    DSEL_MOD
  } div_sel_t;

  typedef enum logic [3:0] {
    ST_IDLE,
    ST_DECIDE,
    ST_BLEND_GO,
    ST_BLEND_WAIT,
    ST_PLAY_GO,
    ST_PLAY_WAIT,
    ST_CHECK,
    ST_MOD_GO,
    ST_MOD_WAIT,
    ST_FINISH
  } state_t;

  typedef struct packed {
    logic [23:0] play_duration;
    logic [23:0] blend_duration;
    logic [23:0] range_start;
    logic [24:0] range_end;
    logic        play_forward;
    logic        smooth_blend;
    logic [23:0] start_phase;
    logic        use_default_start;
  } cfg_t;

  typedef struct packed {
    logic     capture;
    logic     do_start;
    logic     div_go;
    div_sel_t div_sel;
    logic     blend_apply;
    logic     adv_apply;
    logic     mod_apply;
    logic     finish;
  } cmd_t;

  typedef struct packed {
    logic is_start;
    logic active;
    logic stopped;
    logic need_mod;
    logic out_free;
  } stat_t;

endpackage
`default_nettype wire

/* hw/rtl/animation_phase_controller_unit.sv */
// animation_phase_controller_unit: top level of the animation phase controller
// depends on apc_pkg, apc_cfg, apc_div, apc_ctrl and apc_dp
//
//  channel   direction  handshake              payload
//  in_       slave      in_tvalid/in_tready    in_tuser kind, in_tdata item fields
//  out_      master     out_tvalid/out_tready  out_tdata result fields
//  cfg_      apb slave  psel/penable/pready    8 registers at byte address 4*i
//
// start items and idle ticks skip the divider; stopped ticks divide for blend;
// active ticks divide for blend and play; a subrange wrap adds a modulo one
// each division runs on the shared one-bit-a-step divider
// reset is synchronous and active low; state returns to idle, phase 0, weight 1.0
// a result waits in the output register while the next item is taken in
`default_nettype none
module animation_phase_controller_unit
  import apc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_tvalid,
  output logic             in_tready,
  // [0] kind
  input  wire logic [0:0]  in_tuser,
  // [23:0] elapsed, [26:24] new_mode, [27] had_previous, [51:28] marker
  input  wire logic [55:0] in_tdata,
  output logic             out_tvalid,
  input  wire logic        out_tready,
  // [23:0] phase_out, [48:24] blend_weight, [51:49] mode_out, [52] marker_crossed
  output logic [55:0]      out_tdata,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output logic             cfg_pready
);

  cfg_t  cfg;
  cmd_t  cmd;
  stat_t stat;
  logic [DIVD_W-1:0] div_dividend, div_quo;
  logic [DIVS_W-1:0] div_divisor, div_rem;
  logic div_done;
  logic [52:0] out_data;

  assign cfg_pready = 1'b1;
  assign out_tdata = {3'd0, out_data};

  apc_cfg u_cfg (
    .clk(clk), .rst_n(rst_n),
    .cfg_psel(cfg_psel), .cfg_penable(cfg_penable), .cfg_pwrite(cfg_pwrite),
    .cfg_paddr(cfg_paddr), .cfg_pwdata(cfg_pwdata), .cfg_prdata(cfg_prdata),
    .cfg(cfg)
  );

  apc_div u_div (
    .clk(clk), .rst_n(rst_n), .start(cmd.div_go),
    .dividend(div_dividend), .divisor(div_divisor),
    .done(div_done), .quo(div_quo), .rem(div_rem)
  );

  apc_ctrl u_ctrl (
    .clk(clk), .rst_n(rst_n), .in_tvalid(in_tvalid), .in_tready(in_tready),
    .div_done(div_done), .stat(stat), .cmd(cmd)
  );

  apc_dp u_dp (
    .clk(clk), .rst_n(rst_n), .cfg(cfg), .cmd(cmd), .stat(stat),
    .in_kind(in_tuser[0]), .in_data(in_tdata[51:0]),
    .div_dividend(div_dividend), .div_divisor(div_divisor),
    .div_quo(div_quo), .div_rem(div_rem),
    .out_valid(out_tvalid), .out_ready(out_tready), .out_data(out_data)
  );

endmodule
`default_nettype wire

/* hw/rtl/apc_cfg.sv */
// apc_cfg: configuration register file behind the apb-style port
// depends on apc_pkg for the register indexes and the cfg_t struct
`default_nettype none
module apc_cfg
  import apc_pkg::*;
(
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        cfg_psel,
  input  wire logic        cfg_penable,
  input  wire logic        cfg_pwrite,
  input  wire logic [4:0]  cfg_paddr,
  input  wire logic [31:0] cfg_pwdata,
  output logic [31:0]      cfg_prdata,
  output cfg_t             cfg
);

  cfg_t cfg_r;
  logic wr_en;
  logic [2:0] idx;

  assign idx = cfg_paddr[4:2];
  assign wr_en = cfg_psel && cfg_penable && cfg_pwrite;
  assign cfg = cfg_r;

  // register writes
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      cfg_r.play_duration <= 24'd131072;
      cfg_r.blend_duration <= 24'd13107;
      cfg_r.range_start <= 24'd0;
      cfg_r.range_end <= ONE_Q24;
      cfg_r.play_forward <= 1'b1;
      cfg_r.smooth_blend <= 1'b1;
      cfg_r.start_phase <= 24'd0;
      cfg_r.use_default_start <= 1'b1;
    end else if (wr_en) begin
      case (idx)
        REG_PLAY_DUR: cfg_r.play_duration <= cfg_pwdata[23:0];
        REG_BLEND_DUR: cfg_r.blend_duration <= cfg_pwdata[23:0];
        REG_RANGE_START: cfg_r.range_start <= cfg_pwdata[23:0];
        REG_RANGE_END: cfg_r.range_end <= cfg_pwdata[24:0];
        REG_PLAY_FWD: cfg_r.play_forward <= cfg_pwdata[0];
        REG_SMOOTH: cfg_r.smooth_blend <= cfg_pwdata[0];
        REG_START_PHASE: cfg_r.start_phase <= cfg_pwdata[23:0];
        REG_USE_DEFAULT: cfg_r.use_default_start <= cfg_pwdata[0];
        default: ;
      endcase
    end
  end

  // read mux
  always_comb begin
    case (idx)
      REG_PLAY_DUR: cfg_prdata = {8'd0, cfg_r.play_duration};
      REG_BLEND_DUR: cfg_prdata = {8'd0, cfg_r.blend_duration};
      REG_RANGE_START: cfg_prdata = {8'd0, cfg_r.range_start};
      REG_RANGE_END: cfg_prdata = {7'd0, cfg_r.range_end};
      REG_PLAY_FWD: cfg_prdata = {31'd0, cfg_r.play_forward};
      REG_SMOOTH: cfg_prdata = {31'd0, cfg_r.smooth_blend};
      REG_START_PHASE: cfg_prdata = {8'd0, cfg_r.start_phase};
      REG_USE_DEFAULT: cfg_prdata = {31'd0, cfg_r.use_default_start};
      default: cfg_prdata = 32'd0;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/apc_div.sv */
// apc_div: restoring divider, one quotient bit per cycle
// depends on apc_pkg for operand widths
`default_nettype none
module apc_div
  import apc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  wire logic              start,
  input  wire logic [DIVD_W-1:0] dividend,
  input  wire logic [DIVS_W-1:0] divisor,
  output logic                   done,
  output logic [DIVD_W-1:0]      quo,
  output logic [DIVS_W-1:0]      rem
);

  localparam logic [5:0] LAST = 6'(DIVD_W - 1);

  logic busy_r, busy_nxt;
  logic done_r, done_nxt;
  logic [5:0] cnt_r, cnt_nxt;
  logic [DIVS_W-1:0] acc_r, acc_nxt;
  logic [DIVD_W-1:0] q_r, q_nxt;
  logic [DIVS_W-1:0] div_r, div_nxt;
  logic [DIVS_W:0] trial;
  logic ge;

  assign trial = {acc_r, q_r[DIVD_W-1]};
  assign ge = trial >= {1'b0, div_r};

  // one shift-subtract step per cycle
  always_comb begin
    busy_nxt = busy_r;
    done_nxt = 1'b0;
    cnt_nxt = cnt_r;
    acc_nxt = acc_r;
    q_nxt = q_r;
    div_nxt = div_r;
    if (start) begin
      busy_nxt = 1'b1;
      cnt_nxt = 6'd0;
      acc_nxt = '0;
      q_nxt = dividend;
      div_nxt = divisor;
    end else if (busy_r) begin
      acc_nxt = ge ? DIVS_W'(trial - {1'b0, div_r}) : trial[DIVS_W-1:0];
      q_nxt = {q_r[DIVD_W-2:0], ge};
      cnt_nxt = cnt_r + 6'd1;
      if (cnt_r == LAST) begin
        busy_nxt = 1'b0;
        done_nxt = 1'b1;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      busy_r <= 1'b0;
      done_r <= 1'b0;
      cnt_r <= 6'd0;
    end else begin
      busy_r <= busy_nxt;
      done_r <= done_nxt;
      cnt_r <= cnt_nxt;
    end
  end

  always_ff @(posedge clk) begin
    acc_r <= acc_nxt;
    q_r <= q_nxt;
    div_r <= div_nxt;
  end

  assign done = done_r;
  assign quo = q_r;
  assign rem = acc_r;

endmodule
`default_nettype wire

/* hw/rtl/apc_ctrl.sv */
// apc_ctrl: sequencer that steps an item through blend, advance and wrap
// depends on apc_pkg for state_t, cmd_t and stat_t
`default_nettype none
module apc_ctrl
  import apc_pkg::*;
(
  input  wire logic clk,
  input  wire logic rst_n,
  input  wire logic in_tvalid,
  output logic      in_tready,
  input  wire logic div_done,
  input  stat_t     stat,
  output cmd_t      cmd
);

  state_t state_r, state_nxt;

  always_ff @(posedge clk) begin
    if (!rst_n) state_r <= ST_IDLE;
    else state_r <= state_nxt;
  end

  // next state and commands
  always_comb begin
    state_nxt = state_r;
    cmd = '0;
    cmd.div_sel = DSEL_BLEND;
    in_tready = 1'b0;
    case (state_r)
      ST_IDLE: begin
        in_tready = 1'b1;
        if (in_tvalid) begin
          cmd.capture = 1'b1;
          state_nxt = ST_DECIDE;
        end
      end
      ST_DECIDE: begin
        if (stat.is_start) begin
          cmd.do_start = 1'b1;
          state_nxt = ST_FINISH;
        end else if (stat.active || stat.stopped) begin
          state_nxt = ST_BLEND_GO;
        end else begin
          state_nxt = ST_FINISH;
        end
      end
      ST_BLEND_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_sel = DSEL_BLEND;
        state_nxt = ST_BLEND_WAIT;
      end
      ST_BLEND_WAIT: begin
        if (div_done) begin
          cmd.blend_apply = 1'b1;
          state_nxt = stat.stopped ? ST_FINISH : ST_PLAY_GO;
        end
      end
      ST_PLAY_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_sel = DSEL_PLAY;
        state_nxt = ST_PLAY_WAIT;
      end
      ST_PLAY_WAIT: begin
        // keep the play select so the zero-duration check sees play_duration
        cmd.div_sel = DSEL_PLAY;
        if (div_done) begin
          cmd.adv_apply = 1'b1;
          state_nxt = ST_CHECK;
        end
      end
      ST_CHECK: begin
        state_nxt = stat.need_mod ? ST_MOD_GO : ST_FINISH;
      end
      ST_MOD_GO: begin
        cmd.div_go = 1'b1;
        cmd.div_sel = DSEL_MOD;
        state_nxt = ST_MOD_WAIT;
      end
      ST_MOD_WAIT: begin
        cmd.div_sel = DSEL_MOD;
        if (div_done) begin
          cmd.mod_apply = 1'b1;
          state_nxt = ST_FINISH;
        end
      end
      ST_FINISH: begin
        if (stat.out_free) begin
          cmd.finish = 1'b1;
          state_nxt = ST_IDLE;
        end
      end
      default: state_nxt = ST_IDLE;
    endcase
  end

endmodule
`default_nettype wire

/* hw/rtl/apc_dp.sv */
// apc_dp: playback state, phase advance, wrap, blend ramp, marker test, output register
// depends on apc_pkg; divider operands leave and results return through ports
`default_nettype none
module apc_dp
  import apc_pkg::*;
(
  input  wire logic              clk,
  input  wire logic              rst_n,
  input  cfg_t                   cfg,
  input  cmd_t                   cmd,
  output stat_t                  stat,
  input  wire logic              in_kind,
  input  wire logic [51:0]       in_data,
  output logic [DIVD_W-1:0]      div_dividend,
  output logic [DIVS_W-1:0]      div_divisor,
  input  wire logic [DIVD_W-1:0] div_quo,
  input  wire logic [DIVS_W-1:0] div_rem,
  output logic                   out_valid,
  input  wire logic              out_ready,
  output logic [52:0]            out_data
);

  // captured item
  logic        kind_r;
  logic [23:0] elapsed_r;
  logic [2:0]  nmode_r;
  logic        had_prev_r;
  logic [23:0] marker_r;

  // playback state
  logic [23:0] phase_r;
  logic [23:0] prev_r;
  logic [24:0] weight_r;
  logic [2:0]  mode_r;
  logic        need_mod_r;
  logic [49:0] mod_num_r;

  logic        out_valid_r;
  logic [52:0] out_data_r;

  logic [24:0] end_w;
  logic [47:0] ratio;
  logic [48:0] wsum;
  logic signed [50:0] t_w;
  logic signed [50:0] end_s;
  logic [23:0] once_cap;
  logic        hit;

  assign end_w = (cfg.range_end > ONE_Q24) ? ONE_Q24 : cfg.range_end;
  assign end_s = signed'({26'd0, end_w});

  // divider operands
  always_comb begin
    case (cmd.div_sel)
      DSEL_BLEND: begin
        div_dividend = {2'd0, elapsed_r, 24'd0};
        div_divisor = {1'b0, cfg.blend_duration};
      end
      DSEL_PLAY: begin
        div_dividend = {2'd0, elapsed_r, 24'd0};
        div_divisor = {1'b0, cfg.play_duration};
      end
      DSEL_MOD: begin
        div_dividend = mod_num_r;
        div_divisor = 25'(end_w - {1'b0, cfg.range_start});
      end
      default: begin
        div_dividend = '0;
        div_divisor = '0;
      end
    endcase
  end

  // saturated step from the divider
  always_comb begin
    if (cmd.div_sel == DSEL_BLEND)
      ratio = (cfg.blend_duration == 24'd0) ? DELTA_MAX : div_quo[47:0];
    else
      ratio = (cfg.play_duration == 24'd0) ? DELTA_MAX : div_quo[47:0];
  end

  assign wsum = {24'd0, weight_r} + {1'b0, ratio};
  assign t_w = cfg.play_forward ? signed'({27'd0, phase_r} + {3'd0, ratio})
                                : signed'({27'd0, phase_r} - {3'd0, ratio});
  assign once_cap = (end_w[23:0] > NEAR_ONE || end_w[24]) ? NEAR_ONE : end_w[23:0];

  // marker crossing
  always_comb begin
    if (phase_r == prev_r) hit = 1'b0;
    else if (cfg.play_forward) begin
      if (prev_r < phase_r) hit = (prev_r <= marker_r) && (marker_r < phase_r);
      else hit = (prev_r <= marker_r) || (marker_r < phase_r);
    end else begin
      if (phase_r < prev_r) hit = (marker_r <= prev_r) && (phase_r < marker_r);
      else hit = (marker_r <= prev_r) || (phase_r < marker_r);
    end
  end

  // input capture
  always_ff @(posedge clk) begin
    if (cmd.capture) begin
      kind_r <= in_kind;
      elapsed_r <= in_data[23:0];
      nmode_r <= in_data[26:24];
      had_prev_r <= in_data[27];
      marker_r <= in_data[51:28];
    end
  end

  // state updates
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      phase_r <= 24'd0;
      prev_r <= 24'd0;
      weight_r <= ONE_Q24;
      mode_r <= MODE_IDLE;
      need_mod_r <= 1'b0;
    end else begin
      if (cmd.do_start) begin
        mode_r <= (nmode_r > MODE_STOPPED) ? MODE_IDLE : nmode_r;
        weight_r <= (cfg.smooth_blend && had_prev_r) ? 25'd0 : ONE_Q24;
        if (cfg.use_default_start) begin
          phase_r <= cfg.play_forward ? 24'd0 : NEAR_ONE;
          prev_r <= cfg.play_forward ? 24'd0 : NEAR_ONE;
        end else begin
          phase_r <= cfg.start_phase;
          prev_r <= cfg.start_phase;
        end
      end
      if (cmd.blend_apply && cfg.smooth_blend && weight_r < ONE_Q24)
        weight_r <= (wsum > {24'd0, ONE_Q24}) ? ONE_Q24 : wsum[24:0];
      if (cmd.adv_apply) begin
        prev_r <= phase_r;
        need_mod_r <= 1'b0;
        case (mode_r)
          MODE_LOOP: phase_r <= t_w[23:0];
          MODE_SUB: begin
            if (t_w >= end_s) begin
              if (end_w <= {1'b0, cfg.range_start}) phase_r <= cfg.range_start;
              else need_mod_r <= 1'b1;
            end else if (t_w < 0) begin
              phase_r <= 24'd0;
            end else begin
              phase_r <= t_w[23:0];
            end
          end
          default: begin
            if (t_w < 0) begin
              phase_r <= 24'd0;
              mode_r <= MODE_STOPPED;
            end else if (t_w > end_s || t_w > signed'({27'd0, NEAR_ONE})) begin
              phase_r <= (t_w > end_s) ? once_cap
                                       : NEAR_ONE;
              mode_r <= MODE_STOPPED;
            end else begin
              phase_r <= t_w[23:0];
            end
          end
        endcase
      end
      if (cmd.mod_apply) begin
        phase_r <= 24'(cfg.range_start + div_rem[23:0]);
        need_mod_r <= 1'b0;
      end
    end
  end

  // subrange offset for the wrap
  always_ff @(posedge clk) begin
    if (cmd.adv_apply) mod_num_r <= 50'(t_w - signed'({27'd0, cfg.range_start}));
  end

  // output register
  always_ff @(posedge clk) begin
    if (!rst_n) out_valid_r <= 1'b0;
    else if (cmd.finish) out_valid_r <= 1'b1;
    else if (out_ready) out_valid_r <= 1'b0;
  end

  always_ff @(posedge clk) begin
    if (cmd.finish) out_data_r <= {hit, mode_r, weight_r, phase_r};
  end

  assign out_valid = out_valid_r;
  assign out_data = out_data_r;

  assign stat.is_start = kind_r;
  assign stat.active = (mode_r == MODE_ONCE) || (mode_r == MODE_LOOP) || (mode_r == MODE_SUB);
  assign stat.stopped = (mode_r == MODE_STOPPED);
  assign stat.need_mod = need_mod_r;
  assign stat.out_free = !out_valid_r || out_ready;

endmodule
`default_nettype wire
